// ----- hdl/assert_macros.svh -----
// Assertion macros shared by the allocator modules.
// Every macro samples on clk and is switched off while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that an expression holds at every clock edge.
`define BCA_ASSERT(name, expr, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Check that a condition implies a consequence in the same cycle.
`define BCA_IMPLY(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Check that a condition implies a consequence in the next cycle.
`define BCA_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hdl/bca_pkg.sv -----
// Shared types and constants for the block chain allocator.
// No dependencies; every other file of the block but assert_macros.svh uses it.
`timescale 1ns / 1ps

package bca_pkg;

  localparam int NUM_BLOCKS_DEF = 1024;
  localparam int BLOCK_W        = 10;
  localparam int OP_W           = 2;
  localparam int STAT_W         = 2;

  typedef enum logic [OP_W-1:0] {
    OP_ALLOC,
    OP_FREE,
    OP_EXTEND,
    OP_FOLLOW
  } op_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK,
    STAT_FULL,
    STAT_BROKEN
  } status_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_DISPATCH,
    S_LOOK,
    S_SCAN,
    S_LINK,
    S_WALK,
    S_FINISH
  } state_t;

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_CLEAR,
    CMD_LATCH,
    CMD_SCAN_INIT,
    CMD_SCAN_STEP,
    CMD_SCAN_TAKE,
    CMD_READ_BLK,
    CMD_WALK,
    CMD_LINK,
    CMD_OK_LINK,
    CMD_LOAD_OUT
  } cmd_t;

  typedef struct packed {
    cmd_t    cmd;
    logic    set_st;
    status_t st;
  } ctrl_t;

  typedef struct packed {
    logic clr_last;
    logic blk_ok;
    logic rd_zero;
    logic rd_end;
    logic rd_bad;
    logic chk_vld;
    logic ptr_end;
  } dp_stat_t;

endpackage

// ----- hdl/bca_if.sv -----
// Valid/ready channel interfaces for the allocator request and result streams.
// Depends on bca_pkg for the field widths.
`timescale 1ns / 1ps

interface bca_in_if;
  logic                         valid;
  logic                         ready;
  logic [bca_pkg::OP_W-1:0]     operation;
  logic [bca_pkg::BLOCK_W-1:0]  block;

  modport source (output valid, output operation, output block, input ready);
  modport sink   (input valid, input operation, input block, output ready);
endinterface

interface bca_out_if;
  logic                         valid;
  logic                         ready;
  logic [bca_pkg::BLOCK_W-1:0]  result_block;
  logic [bca_pkg::STAT_W-1:0]   status;

  modport source (output valid, output result_block, output status, input ready);
  modport sink   (input valid, input result_block, input status, output ready);
endinterface

// ----- hdl/bca_ctrl.sv -----
// Sequencer of the block chain allocator: request/result handshakes and the
// per-operation state machine. Depends on bca_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module bca_ctrl (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [bca_pkg::OP_W-1:0] in_operation,
  output logic                     out_valid,
  input  logic                     out_ready,
  output bca_pkg::ctrl_t           ctrl,
  input  bca_pkg::dp_stat_t        stat
);

  bca_pkg::state_t state_r, state_nxt;
  bca_pkg::op_t    op_r, op_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic            out_free;
  logic            found;

  assign out_free = !out_valid_r || out_ready;
  assign found    = stat.chk_vld && stat.rd_zero;
  assign op_nxt   = (state_r == bca_pkg::S_IDLE && in_valid) ?
                    bca_pkg::op_t'(in_operation) : op_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bca_pkg::S_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r <= op_nxt;
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      bca_pkg::S_CLEAR: begin
        if (stat.clr_last) state_nxt = bca_pkg::S_IDLE;
      end
      bca_pkg::S_IDLE: begin
        if (in_valid) state_nxt = bca_pkg::S_DISPATCH;
      end
      bca_pkg::S_DISPATCH: begin
        priority if (op_r == bca_pkg::OP_ALLOC) state_nxt = bca_pkg::S_SCAN;
        else if (!stat.blk_ok)                  state_nxt = bca_pkg::S_FINISH;
        else if (op_r == bca_pkg::OP_FREE)      state_nxt = bca_pkg::S_WALK;
        else                                    state_nxt = bca_pkg::S_LOOK;
      end
      bca_pkg::S_LOOK: begin
        if (stat.rd_end && op_r == bca_pkg::OP_EXTEND) state_nxt = bca_pkg::S_SCAN;
        else                                           state_nxt = bca_pkg::S_FINISH;
      end
      bca_pkg::S_SCAN: begin
        priority if (found) begin
          state_nxt = (op_r == bca_pkg::OP_EXTEND) ? bca_pkg::S_LINK : bca_pkg::S_FINISH;
        end else if (stat.ptr_end) begin
          state_nxt = bca_pkg::S_FINISH;
        end else begin
          state_nxt = bca_pkg::S_SCAN;
        end
      end
      bca_pkg::S_LINK: begin
        state_nxt = bca_pkg::S_FINISH;
      end
      bca_pkg::S_WALK: begin
        if (stat.rd_zero || stat.rd_end || stat.rd_bad) state_nxt = bca_pkg::S_FINISH;
      end
      bca_pkg::S_FINISH: begin
        if (out_free) state_nxt = bca_pkg::S_IDLE;
      end
    endcase
  end

  // Commands to the datapath
  always_comb begin
    ctrl.cmd    = bca_pkg::CMD_NONE;
    ctrl.set_st = 1'b0;
    ctrl.st     = bca_pkg::STAT_BROKEN;
    unique case (state_r)
      bca_pkg::S_CLEAR: begin
        ctrl.cmd = bca_pkg::CMD_CLEAR;
      end
      bca_pkg::S_IDLE: begin
        if (in_valid) ctrl.cmd = bca_pkg::CMD_LATCH;
      end
      bca_pkg::S_DISPATCH: begin
        priority if (op_r == bca_pkg::OP_ALLOC) begin
          ctrl.cmd = bca_pkg::CMD_SCAN_INIT;
        end else if (!stat.blk_ok) begin
          ctrl.set_st = 1'b1;
        end else begin
          ctrl.cmd = bca_pkg::CMD_READ_BLK;
        end
      end
      bca_pkg::S_LOOK: begin
        priority if (stat.rd_zero || stat.rd_bad) begin
          ctrl.set_st = 1'b1;
        end else if (!stat.rd_end) begin
          ctrl.cmd = bca_pkg::CMD_OK_LINK;
        end else if (op_r == bca_pkg::OP_FOLLOW) begin
          ctrl.set_st = 1'b1;
        end else begin
          ctrl.cmd = bca_pkg::CMD_SCAN_INIT;
        end
      end
      bca_pkg::S_SCAN: begin
        priority if (found) begin
          ctrl.cmd = bca_pkg::CMD_SCAN_TAKE;
        end else if (stat.ptr_end) begin
          ctrl.set_st = 1'b1;
          ctrl.st     = bca_pkg::STAT_FULL;
        end else begin
          ctrl.cmd = bca_pkg::CMD_SCAN_STEP;
        end
      end
      bca_pkg::S_LINK: begin
        ctrl.cmd = bca_pkg::CMD_LINK;
      end
      bca_pkg::S_WALK: begin
        if (stat.rd_zero) begin
          ctrl.set_st = 1'b1;
        end else begin
          // clear this entry; a link past the table ends the walk as broken
          ctrl.cmd    = bca_pkg::CMD_WALK;
          ctrl.set_st = stat.rd_bad;
        end
      end
      bca_pkg::S_FINISH: begin
        if (out_free) ctrl.cmd = bca_pkg::CMD_LOAD_OUT;
      end
    endcase
  end

  assign in_ready      = (state_r == bca_pkg::S_IDLE);
  assign out_valid     = out_valid_r;
  assign out_valid_nxt = (ctrl.cmd == bca_pkg::CMD_LOAD_OUT) || (out_valid_r && !out_ready);

  `BCA_IMPLY(out_from_finish, $rose(out_valid_r), $past(state_r == bca_pkg::S_FINISH), "result raised outside finish")
  `BCA_NEXT(accept_dispatch, in_valid && in_ready, state_r == bca_pkg::S_DISPATCH, "accepted request not dispatched")

endmodule

// ----- hdl/bca_dp.sv -----
// Datapath of the block chain allocator: link table memory, scan pointer,
// search hint, chain walker and result register. Depends on bca_pkg.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module bca_dp #(
  parameter int NUM_BLOCKS = bca_pkg::NUM_BLOCKS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [bca_pkg::BLOCK_W-1:0] in_block,
  output logic [bca_pkg::BLOCK_W-1:0] out_result_block,
  output logic [bca_pkg::STAT_W-1:0]  out_status,
  input  bca_pkg::ctrl_t              ctrl,
  output bca_pkg::dp_stat_t           stat
);

  localparam int AW = $clog2(NUM_BLOCKS);
  localparam int PW = AW + 1;
  localparam int EW = AW + 1;
  localparam int CW = (bca_pkg::BLOCK_W > PW) ? bca_pkg::BLOCK_W : PW;
  localparam logic [PW-1:0] NB       = PW'(NUM_BLOCKS);
  localparam logic [PW-1:0] NB_LAST  = PW'(NUM_BLOCKS - 1);
  localparam logic [EW-1:0] END_LINK = {1'b1, {AW{1'b0}}};

  // Entry: all zero = free, top bit = end of chain, else low bits = next block
  logic [EW-1:0] mem [NUM_BLOCKS];
  logic [EW-1:0] rd_data_r;

  logic [PW-1:0] ptr_r, ptr_nxt;
  logic          chk_vld_r, chk_vld_nxt;
  logic [PW-1:0] hint_r, hint_nxt;
  logic [AW-1:0] chk_r, chk_nxt;
  logic [bca_pkg::BLOCK_W-1:0] blk_r, blk_nxt;
  logic [AW-1:0] j_r, j_nxt;
  logic [AW-1:0] res_r, res_nxt;
  bca_pkg::status_t st_r, st_nxt;
  logic [bca_pkg::BLOCK_W-1:0] out_block_r, out_block_nxt;
  bca_pkg::status_t out_status_r, out_status_nxt;

  logic [CW-1:0] blk_ext;
  logic [AW-1:0] blk_a;
  logic [AW-1:0] rd_link;
  logic [AW-1:0] rd_addr;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [EW-1:0] wr_data;

  assign blk_ext = CW'(blk_r);
  assign blk_a   = AW'(blk_r);
  assign rd_link = rd_data_r[AW-1:0];

  // Link table port selection
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = ptr_r[AW-1:0];
    wr_data = '0;
    rd_addr = ptr_r[AW-1:0];
    unique case (ctrl.cmd)
      bca_pkg::CMD_CLEAR: begin
        wr_en = 1'b1;
      end
      bca_pkg::CMD_SCAN_TAKE: begin
        wr_en   = 1'b1;
        wr_addr = chk_r;
        wr_data = END_LINK;
      end
      bca_pkg::CMD_READ_BLK: begin
        rd_addr = blk_a;
      end
      bca_pkg::CMD_WALK: begin
        wr_en   = 1'b1;
        wr_addr = j_r;
        rd_addr = rd_link;
      end
      bca_pkg::CMD_LINK: begin
        wr_en   = 1'b1;
        wr_addr = blk_a;
        wr_data = {1'b0, res_r};
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data_r <= mem[rd_addr];
  end

  // Next values
  always_comb begin
    ptr_nxt        = ptr_r;
    chk_vld_nxt    = chk_vld_r;
    hint_nxt       = hint_r;
    chk_nxt        = chk_r;
    blk_nxt        = blk_r;
    j_nxt          = j_r;
    res_nxt        = res_r;
    st_nxt         = ctrl.set_st ? ctrl.st : st_r;
    out_block_nxt  = out_block_r;
    out_status_nxt = out_status_r;
    unique case (ctrl.cmd)
      bca_pkg::CMD_CLEAR: begin
        ptr_nxt = ptr_r + PW'(1);
      end
      bca_pkg::CMD_LATCH: begin
        blk_nxt = in_block;
        res_nxt = '0;
        st_nxt  = bca_pkg::STAT_OK;
      end
      bca_pkg::CMD_SCAN_INIT: begin
        ptr_nxt     = hint_r;
        chk_vld_nxt = 1'b0;
      end
      bca_pkg::CMD_SCAN_STEP: begin
        // read ptr now; its data is checked next cycle
        ptr_nxt     = ptr_r + PW'(1);
        chk_nxt     = ptr_r[AW-1:0];
        chk_vld_nxt = 1'b1;
      end
      bca_pkg::CMD_SCAN_TAKE: begin
        res_nxt  = chk_r;
        hint_nxt = PW'(chk_r) + PW'(1);
      end
      bca_pkg::CMD_READ_BLK: begin
        j_nxt = blk_a;
      end
      bca_pkg::CMD_WALK: begin
        j_nxt = rd_link;
        if (PW'(j_r) < hint_r) hint_nxt = PW'(j_r);
      end
      bca_pkg::CMD_OK_LINK: begin
        res_nxt = rd_link;
      end
      bca_pkg::CMD_LOAD_OUT: begin
        out_block_nxt  = bca_pkg::BLOCK_W'(res_r);
        out_status_nxt = st_r;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_r     <= '0;
      chk_vld_r <= 1'b0;
      hint_r    <= PW'(1);
    end else begin
      ptr_r     <= ptr_nxt;
      chk_vld_r <= chk_vld_nxt;
      hint_r    <= hint_nxt;
    end
  end

  always_ff @(posedge clk) begin
    chk_r        <= chk_nxt;
    blk_r        <= blk_nxt;
    j_r          <= j_nxt;
    res_r        <= res_nxt;
    st_r         <= st_nxt;
    out_block_r  <= out_block_nxt;
    out_status_r <= out_status_nxt;
  end

  assign stat.clr_last = (ptr_r == NB_LAST);
  assign stat.blk_ok   = (blk_ext != '0) && (blk_ext < CW'(NUM_BLOCKS));
  assign stat.rd_zero  = (rd_data_r == '0);
  assign stat.rd_end   = rd_data_r[AW];
  assign stat.rd_bad   = !rd_data_r[AW] && (PW'(rd_link) >= NB);
  assign stat.chk_vld  = chk_vld_r;
  assign stat.ptr_end  = (ptr_r == NB);

  assign out_result_block = out_block_r;
  assign out_status       = out_status_r;

  `BCA_ASSERT(hint_range, hint_r != '0 && hint_r <= NB, "search hint out of range")
  `BCA_IMPLY(take_is_free, ctrl.cmd == bca_pkg::CMD_SCAN_TAKE, chk_vld_r && rd_data_r == '0, "allocated a busy block")
  `BCA_IMPLY(walk_is_live, ctrl.cmd == bca_pkg::CMD_WALK, rd_data_r != '0, "chain walk cleared a free entry")

endmodule

// ----- hdl/block_chain_allocator.sv -----
// Block chain allocator: a link table of NUM_BLOCKS entries (free, end of
// chain, or next block) with first-fit allocation from a search hint. After
// reset the table is cleared in one pass over its entries, during which no
// request is taken. Every request gives exactly one result. One request is
// worked at a time, limited by the single read port of the table, one entry
// per cycle: allocate examines entries upward from the hint, up to the end of
// the table, free walks the chain, follow reads one entry, and extend at a
// chain end reads its entry and then scans like allocate. A new request is
// taken while a result still waits in the output register. Depends on
// bca_pkg, bca_if, bca_ctrl and bca_dp.
`timescale 1ns / 1ps

module block_chain_allocator #(
  parameter int NUM_BLOCKS = bca_pkg::NUM_BLOCKS_DEF
) (
  input logic       clk,
  input logic       rst_n,
  bca_in_if.sink    in_ch,
  bca_out_if.source out_ch
);

  bca_pkg::ctrl_t    ctrl;
  bca_pkg::dp_stat_t stat;

  bca_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_ch.valid),
    .in_ready     (in_ch.ready),
    .in_operation (in_ch.operation),
    .out_valid    (out_ch.valid),
    .out_ready    (out_ch.ready),
    .ctrl         (ctrl),
    .stat         (stat)
  );

  bca_dp #(
    .NUM_BLOCKS (NUM_BLOCKS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_block         (in_ch.block),
    .out_result_block (out_ch.result_block),
    .out_status       (out_ch.status),
    .ctrl             (ctrl),
    .stat             (stat)
  );

endmodule
